// File: rtl/dmwbc_pkg.sv
// Shared types, constants and helpers for the direct-mapped write-back cache.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package dmwbc_pkg;

	// Geometry. SET_COUNT and STORE_WORDS are powers of two, so that set and
	// store indices are plain low bits of the address.
	localparam int SET_COUNT   = 16;
	localparam int STORE_WORDS = 4096;
	localparam int WORD_BITS   = 18;

	// Fixed field widths of the request and response beats.
	localparam int MODE_BITS = 3;
	localparam int ADDR_BITS = 12;
	localparam int DATA_BITS = 18;
	localparam int CNT_BITS  = 32;

	localparam int SET_AW   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int STORE_AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	// Operation codes.
	localparam logic [MODE_BITS-1:0] MODE_LOAD      = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_STORE     = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_FLUSH     = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_INVAL     = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_FLUSH_ALL = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_HOST      = 3'd5;

	// Line states.
	localparam logic [1:0] LS_INVALID   = 2'd0;
	localparam logic [1:0] LS_EXCLUSIVE = 2'd1;
	localparam logic [1:0] LS_MODIFIED  = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [STORE_AW-1:0]  store_idx_t;
	typedef logic [SET_AW-1:0]    set_idx_t;

	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic [ADDR_BITS-1:0] address;
		logic [DATA_BITS-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] read_data;
		logic                 load_hit;
		logic                 wrote_back;
		logic [CNT_BITS-1:0]  hit_total;
		logic [CNT_BITS-1:0]  miss_total;
		logic [CNT_BITS-1:0]  eviction_total;
	} rsp_t;

	// One read and one write on the backing store per cycle.
	typedef struct packed {
		logic       we;
		store_idx_t waddr;
		word_t      wdata;
		logic       re;
		store_idx_t raddr;
	} store_cmd_t;

	function automatic set_idx_t set_of(input logic [ADDR_BITS-1:0] addr);
		return SET_AW'(addr);
	endfunction

	function automatic store_idx_t store_of(input logic [ADDR_BITS-1:0] addr);
		return STORE_AW'(addr);
	endfunction

endpackage

`default_nettype wire

// File: rtl/dmwbc_store.sv
// Backing word store: one write and one registered read port, with a zeroing
// sweep after reset. Depends on dmwbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmwbc_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dmwbc_pkg::store_cmd_t  cmd,
	output dmwbc_pkg::word_t       rdata,
	output logic                   cleared
);
	import dmwbc_pkg::*;

	word_t      mem [STORE_WORDS];
	word_t      rdata_q;
	store_idx_t clr_idx_q;
	logic       cleared_q;

	// The sweep owns the write port until every word has been zeroed.
	always_ff @(posedge clk) begin
		if (!cleared_q) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata_q <= mem[cmd.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			cleared_q <= 1'b0;
		end else if (!cleared_q) begin
			clr_idx_q <= clr_idx_q + STORE_AW'(1);
			if (clr_idx_q == STORE_AW'(STORE_WORDS - 1)) begin
				cleared_q <= 1'b1;
			end
		end
	end

	assign rdata   = rdata_q;
	assign cleared = cleared_q;

endmodule

`default_nettype wire

// File: rtl/direct_mapped_write_back_cache.sv
// Top level of the direct-mapped write-back cache: control sequencer, line
// memory and line states. Depends on dmwbc_pkg and dmwbc_store.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake             payload
//  req       in   req_valid/req_ready   req  (mode, address, write_data)
//  rsp       out  rsp_valid/rsp_ready   rsp  (read_data, load_hit, wrote_back, totals)
//
//  For a load, store, flush, invalidate or host write, the beat is accepted while the
//  line memory and backing store are read, and ST_LOOK then decides, writes back
//  and loads the response register.
//  Flush all walks the line memory one set per cycle, stalling only on the last set.
//  After reset the backing store is zeroed with req_ready low.
//  The deciding cycle holds while the response register is full and not taken.

module direct_mapped_write_back_cache (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dmwbc_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dmwbc_pkg::rsp_t rsp
);
	import dmwbc_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	// A line in the line memory: full address as tag plus the cached word.
	typedef struct packed {
		logic [ADDR_BITS-1:0] tag;
		word_t                word;
	} line_t;

	logic [1:0]          state_q;
	req_t                req_s1;
	line_t               line_rd_s1;
	line_t               lmem [SET_COUNT];
	logic [1:0]          line_state_q [SET_COUNT];
	set_idx_t            walk_q;
	logic                wb_walk_q;
	logic [CNT_BITS-1:0] hit_q;
	logic [CNT_BITS-1:0] miss_q;
	logic [CNT_BITS-1:0] evict_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	store_cmd_t          sc;
	word_t               store_rdata;
	logic                store_cleared;

	logic                req_fire;
	logic                out_free;
	logic                walk_last;
	logic                go_walk;
	set_idx_t            set_s1;
	word_t               data_s1;
	set_idx_t            st_idx;
	logic [1:0]          cur_st;
	logic                match;
	word_t               fetch;

	logic                lm_re;
	set_idx_t            lm_raddr;
	logic                lm_we;
	line_t               lm_wdata;
	logic                st_we;
	logic [1:0]          st_wval;
	logic                hit_inc;
	logic                miss_inc;
	logic                ev_inc;
	logic                wb;
	word_t               rd;
	logic                finish;
	rsp_t                rsp_d;

	dmwbc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (sc),
		.rdata   (store_rdata),
		.cleared (store_cleared)
	);

	// Requests are only taken between items and once the store is zeroed.
	assign req_ready = store_cleared && (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign walk_last = (walk_q == SET_AW'(SET_COUNT - 1));
	assign go_walk   = !walk_last || out_free;

	assign set_s1  = set_of(req_s1.address);
	assign data_s1 = WORD_BITS'(req_s1.write_data);

	// The walk inspects its own set; every other operation works on the
	// set of the registered address.
	assign st_idx = (state_q == ST_WALK) ? walk_q : set_s1;
	assign cur_st = line_state_q[st_idx];
	assign match  = (cur_st != LS_INVALID) && (line_rd_s1.tag == req_s1.address);

	// If the displaced line aliases the word being fetched, the fetch must see
	// the written-back value rather than the stale store contents.
	assign fetch = ((cur_st == LS_MODIFIED) &&
		(store_of(line_rd_s1.tag) == store_of(req_s1.address))) ?
		line_rd_s1.word : store_rdata;

	// Line memory read port: the set of the incoming beat on acceptance (set
	// zero for flush all), the following set while walking.
	always_comb begin
		lm_re    = 1'b0;
		lm_raddr = set_of(req.address);
		if (state_q == ST_IDLE) begin
			lm_re = req_fire;
			if (req.mode == MODE_FLUSH_ALL) begin
				lm_raddr = '0;
			end
		end else if (state_q == ST_WALK) begin
			lm_re    = go_walk && !walk_last;
			lm_raddr = walk_q + SET_AW'(1);
		end
	end

	// Decision logic for ST_LOOK and ST_WALK, after the memories have been read.
	always_comb begin
		lm_we     = 1'b0;
		lm_wdata  = '{tag: req_s1.address, word: data_s1};
		st_we     = 1'b0;
		st_wval   = LS_INVALID;
		sc.we     = 1'b0;
		sc.waddr  = store_of(line_rd_s1.tag);
		sc.wdata  = line_rd_s1.word;
		sc.re     = req_fire;
		sc.raddr  = store_of(req.address);
		hit_inc   = 1'b0;
		miss_inc  = 1'b0;
		ev_inc    = 1'b0;
		wb        = 1'b0;
		rd        = '0;
		finish    = 1'b0;
		if ((state_q == ST_LOOK) && out_free) begin
			finish = 1'b1;
			unique case (req_s1.mode)
				MODE_LOAD: begin
					if (match) begin
						hit_inc = 1'b1;
						rd      = line_rd_s1.word;
					end else begin
						miss_inc = 1'b1;
						if (cur_st == LS_MODIFIED) begin
							ev_inc = 1'b1;
							sc.we  = 1'b1;
							wb     = 1'b1;
						end
						rd            = fetch;
						lm_we         = 1'b1;
						lm_wdata.word = fetch;
						st_we         = 1'b1;
						st_wval       = LS_EXCLUSIVE;
					end
				end
				MODE_STORE: begin
					if ((cur_st == LS_MODIFIED) && (line_rd_s1.tag != req_s1.address)) begin
						ev_inc = 1'b1;
						sc.we  = 1'b1;
						wb     = 1'b1;
					end
					lm_we   = 1'b1;
					st_we   = 1'b1;
					st_wval = LS_MODIFIED;
				end
				MODE_FLUSH: begin
					if ((cur_st == LS_MODIFIED) && match) begin
						sc.we   = 1'b1;
						wb      = 1'b1;
						st_we   = 1'b1;
						st_wval = LS_EXCLUSIVE;
					end
				end
				MODE_INVAL: begin
					if (match) begin
						st_we   = 1'b1;
						st_wval = LS_INVALID;
					end
				end
				MODE_HOST: begin
					// Host data goes straight to the store and wins over the line.
					sc.we    = 1'b1;
					sc.waddr = store_of(req_s1.address);
					sc.wdata = data_s1;
					if (match) begin
						st_we   = 1'b1;
						st_wval = LS_INVALID;
					end
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_WALK) && go_walk) begin
			finish = walk_last;
			if (cur_st == LS_MODIFIED) begin
				sc.we   = 1'b1;
				wb      = 1'b1;
				st_we   = 1'b1;
				st_wval = LS_EXCLUSIVE;
			end
		end
	end

	always_comb begin
		rsp_d.read_data      = DATA_BITS'(rd);
		rsp_d.load_hit       = hit_inc;
		rsp_d.wrote_back     = wb || wb_walk_q;
		rsp_d.hit_total      = hit_q + CNT_BITS'(hit_inc);
		rsp_d.miss_total     = miss_q + CNT_BITS'(miss_inc);
		rsp_d.eviction_total = evict_q + CNT_BITS'(ev_inc);
	end

	// Line memory: registered read, written in the deciding cycle only.
	always_ff @(posedge clk) begin
		if (lm_we) begin
			lmem[set_s1] <= lm_wdata;
		end
		if (lm_re) begin
			line_rd_s1 <= lmem[lm_raddr];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	// Control state: sequencer, line states, counters and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_q      <= '0;
			wb_walk_q   <= 1'b0;
			hit_q       <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < SET_COUNT; i++) begin
				line_state_q[i] <= LS_INVALID;
			end
		end else begin
			if (st_we) begin
				line_state_q[st_idx] <= st_wval;
			end
			if (finish) begin
				hit_q   <= rsp_d.hit_total;
				miss_q  <= rsp_d.miss_total;
				evict_q <= rsp_d.eviction_total;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						walk_q    <= '0;
						wb_walk_q <= 1'b0;
						state_q   <= (req.mode == MODE_FLUSH_ALL) ? ST_WALK : ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (go_walk) begin
						wb_walk_q <= wb_walk_q || wb;
						walk_q    <= walk_q + SET_AW'(1);
						if (walk_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: rtl/dmwbc_checker.sv
// Port-level checks for the direct-mapped write-back cache, bound to the top.
// Depends on dmwbc_pkg and direct_mapped_write_back_cache.
`timescale 1ns / 1ps
`default_nettype none

module dmwbc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input dmwbc_pkg::rsp_t rsp
);
	import dmwbc_pkg::*;

	logic [1:0]          pend_q;
	logic                seen_q;
	logic [CNT_BITS-1:0] last_hit_q;
	logic [CNT_BITS-1:0] last_miss_q;
	logic [CNT_BITS-1:0] last_ev_q;
	logic                req_fire;
	logic                rsp_fire;
	logic [CNT_BITS-1:0] dh;
	logic [CNT_BITS-1:0] dm;
	logic [CNT_BITS-1:0] de;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;
	assign dh = rsp.hit_total - last_hit_q;
	assign dm = rsp.miss_total - last_miss_q;
	assign de = rsp.eviction_total - last_ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_q      <= 1'b0;
			last_hit_q  <= '0;
			last_miss_q <= '0;
			last_ev_q   <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_fire) - 2'(rsp_fire);
			if (rsp_fire) begin
				seen_q      <= 1'b1;
				last_hit_q  <= rsp.hit_total;
				last_miss_q <= rsp.miss_total;
				last_ev_q   <= rsp.eviction_total;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response beat without an outstanding request");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.load_hit |-> !rsp.wrote_back)
		else $error("load hit reported a write-back");

	a_hit_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && seen_q |-> (dh == CNT_BITS'(rsp.load_hit)) &&
			((dm == '0) || ((dm == CNT_BITS'(1)) && (dh == '0))))
		else $error("hit or miss totals moved inconsistently");

	a_evict_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && seen_q |-> (de == '0) || ((de == CNT_BITS'(1)) && rsp.wrote_back))
		else $error("eviction total moved without a write-back");

endmodule

bind direct_mapped_write_back_cache dmwbc_checker u_dmwbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
